// File: src/fpcc_pkg.sv
// Shared types, constants and helper functions for the fractional PLL
// coefficient calculator. No dependencies.
package fpcc_pkg;

    localparam int unsigned MCLK_W   = 26;
    localparam int unsigned RATE_W   = 16;
    localparam int unsigned TGT_W    = 30;   // rate * 1024 * 12 stays below 2**30
    localparam int unsigned QUO_W    = 28;   // rounded ratio below 13 * 2**24
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned NINT_W   = 4;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned OUTHZ_W  = 28;
    localparam int unsigned DIV_STEPS = QUO_W;
    localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

    localparam logic [MCLK_W-1:0] MCLK_MIN_HZ = MCLK_W'(3781000);
    localparam logic [MCLK_W-1:0] MCLK_MAX_HZ = MCLK_W'(32768000);
    localparam logic [NINT_W-1:0] N_MIN       = NINT_W'(6);
    localparam logic [NINT_W-1:0] N_MAX       = NINT_W'(12);
    localparam logic [IDX_W-1:0]  IDX_LAST    = IDX_W'(7);

    // Result status
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Sample rate filter codes
    localparam logic [CODE_W-1:0] FILT_48K = CODE_W'(0);
    localparam logic [CODE_W-1:0] FILT_32K = CODE_W'(1);
    localparam logic [CODE_W-1:0] FILT_22K = CODE_W'(2);
    localparam logic [CODE_W-1:0] FILT_16K = CODE_W'(3);
    localparam logic [CODE_W-1:0] FILT_11K = CODE_W'(4);
    localparam logic [CODE_W-1:0] FILT_8K  = CODE_W'(5);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CAND,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } t_rate_info;

    // Decode a sample rate into its filter code.
    function automatic t_rate_info rate_info(input logic [RATE_W-1:0] rate);
        t_rate_info ri;
        ri.valid = 1'b1;
        unique case (rate) inside
            RATE_W'(8000):  ri.code = FILT_8K;
            RATE_W'(11025): ri.code = FILT_11K;
            RATE_W'(16000): ri.code = FILT_16K;
            RATE_W'(22050): ri.code = FILT_22K;
            RATE_W'(32000): ri.code = FILT_32K;
            RATE_W'(44100),
            RATE_W'(48000): ri.code = FILT_48K;
            default: begin
                ri.valid = 1'b0;
                ri.code  = FILT_48K;
            end
        endcase
        return ri;
    endfunction

    // Target frequency rate * 1024 * ratio for post divider idx.
    // Odd indices use 3*rate (ratios 1.5, 3, 6, 12), even ones rate (1, 2, 4, 8).
    function automatic logic [TGT_W-1:0] target_of(input logic [RATE_W-1:0] rate,
                                                   input logic [IDX_W-1:0]  idx);
        logic [RATE_W+1:0] base;
        logic [31:0]       wide;
        logic [3:0]        sh;
        base = idx[0] ? ({2'b00, rate} + {1'b0, rate, 1'b0}) : {2'b00, rate};
        sh   = (idx[0] ? 4'd9 : 4'd10) + {2'b00, idx[2:1]};
        wide = {{(32-RATE_W-2){1'b0}}, base} << sh;
        return wide[TGT_W-1:0];
    endfunction

endpackage

// File: src/fractional_pll_coeff_calc.sv
// Fractional-N PLL coefficient calculator: searches eight post dividers and
// rounds the PLL ratio through a bit-serial restoring divider.
// Depends on fpcc_pkg.
//
// An invalid rate or clock goes from the prepare state straight to done.
// A candidate whose range check fails is skipped in the candidate state;
// one that fits runs the 28-step bit-serial divider and then the check. A
// candidate inside the window always gives N in 6..12, so at most seven
// misses and one division per beat. A new beat is accepted only in idle.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and empties
// the output register.
module fractional_pll_coeff_calc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // mclk_hz[25:0], fs_hz[41:26], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // pll_int[3:0], pll_frac[27:4], prescale_half[28],
                                     // divider_index[31:29], pll_fout[59:32],
                                     // filter_code[62:60], zero pad
    output logic [0:0]  o_m_tuser    // status[0]
);

    localparam int unsigned MW = fpcc_pkg::MCLK_W;
    localparam int unsigned TW = fpcc_pkg::TGT_W;
    localparam int unsigned QW = fpcc_pkg::QUO_W;

    fpcc_pkg::t_state r_state, n_state;

    // Captured input beat and derived clock multiples
    logic [MW-1:0]                  r_mclk;
    logic [fpcc_pkg::RATE_W-1:0]    r_rate;
    logic [TW-1:0]                  r_m3, r_m6, r_m13;
    logic                           r_in_ok;
    logic [fpcc_pkg::CODE_W-1:0]    r_code;

    // Candidate search
    logic [fpcc_pkg::IDX_W-1:0]     r_idx;
    logic [TW-1:0]                  r_target;
    logic                           r_half;
    logic                           r_found;

    // Bit-serial divider: remainder and a shift register that starts with the
    // low dividend bits and fills with quotient bits from the right
    logic [MW-1:0]                  r_rem;
    logic [QW-1:0]                  r_quo;
    logic [fpcc_pkg::CNT_W-1:0]     r_cnt;

    // Output register
    logic                           r_m_valid;
    logic [63:0]                    r_m_data;
    logic                           r_m_status;

    // Handshake and sequencing strobes
    logic s_accept, load_out;

    // Combinational datapath
    fpcc_pkg::t_rate_info           ri;
    logic [TW-1:0]                  cand_target;
    logic                           cand_fit, cand_half;
    logic [55:0]                    dividend;
    logic [MW:0]                    trial, trial_diff;
    logic                           trial_ge;
    logic [fpcc_pkg::NINT_W-1:0]    quo_int;
    logic                           quo_ok;
    logic                           idx_last, div_last;

    assign s_accept = i_s_tvalid && o_s_tready;

    // Prepare: rate decode; the clock multiples for the range checks are registered
    assign ri = fpcc_pkg::rate_info(r_rate);

    // Candidate: target, range test and dividend (target << (24+half)) + mclk/2.
    // mclk/2 stays below 2**24, so it fills the zero low bits without carry.
    assign cand_target = fpcc_pkg::target_of(r_rate, r_idx);
    assign cand_fit    = (cand_target >= r_m3) && (cand_target < r_m13);
    assign cand_half   = cand_target < r_m6;
    assign dividend    = (cand_half ? ({26'd0, cand_target} << 25)
                                    : ({26'd0, cand_target} << 24))
                       | {31'd0, r_mclk[MW-1:1]};

    // One restoring step per cycle
    assign trial      = {r_rem, r_quo[QW-1]};
    assign trial_diff = trial - {1'b0, r_mclk};
    assign trial_ge   = trial >= {1'b0, r_mclk};

    assign quo_int  = r_quo[QW-1:fpcc_pkg::FRAC_W];
    assign quo_ok   = (quo_int >= fpcc_pkg::N_MIN) && (quo_int <= fpcc_pkg::N_MAX);
    assign idx_last = r_idx == fpcc_pkg::IDX_LAST;
    assign div_last = r_cnt == fpcc_pkg::CNT_W'(fpcc_pkg::DIV_STEPS - 1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpcc_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = fpcc_pkg::ST_PREP;
            end
            fpcc_pkg::ST_PREP: begin
                if (ri.valid && r_mclk >= fpcc_pkg::MCLK_MIN_HZ
                        && r_mclk <= fpcc_pkg::MCLK_MAX_HZ) begin
                    n_state = fpcc_pkg::ST_CAND;
                end else begin
                    n_state = fpcc_pkg::ST_DONE;
                end
            end
            fpcc_pkg::ST_CAND: begin
                if (cand_fit)      n_state = fpcc_pkg::ST_DIV;
                else if (idx_last) n_state = fpcc_pkg::ST_DONE;
            end
            fpcc_pkg::ST_DIV: begin
                if (div_last) n_state = fpcc_pkg::ST_CHECK;
            end
            fpcc_pkg::ST_CHECK: begin
                if (quo_ok || idx_last) n_state = fpcc_pkg::ST_DONE;
                else                    n_state = fpcc_pkg::ST_CAND;
            end
            fpcc_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_tready) n_state = fpcc_pkg::ST_IDLE;
            end
            default: n_state = fpcc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            fpcc_pkg::ST_IDLE: o_s_tready = 1'b1;
            fpcc_pkg::ST_DONE: load_out   = !r_m_valid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mclk <= i_s_tdata[MW-1:0];
            r_rate <= i_s_tdata[MW+fpcc_pkg::RATE_W-1:MW];
        end
        unique case (r_state)
            fpcc_pkg::ST_PREP: begin
                r_m3    <= {3'd0, r_mclk, 1'b0} + {4'd0, r_mclk};
                r_m6    <= {3'd0, r_mclk, 1'b0} + {4'd0, r_mclk} + {3'd0, r_mclk, 1'b0}
                         + {4'd0, r_mclk};
                r_m13   <= {1'b0, r_mclk, 3'd0} + {2'd0, r_mclk, 2'd0} + {4'd0, r_mclk};
                r_in_ok <= ri.valid;
                r_code  <= ri.code;
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            fpcc_pkg::ST_CAND: begin
                r_target <= cand_target;
                r_half   <= cand_half;
                r_rem    <= dividend[53:QW];
                r_quo    <= dividend[QW-1:0];
                r_cnt    <= '0;
                // Advance past a divider whose target is out of range
                if (!cand_fit && !idx_last) r_idx <= r_idx + 1'b1;
            end
            fpcc_pkg::ST_DIV: begin
                r_rem <= trial_ge ? trial_diff[MW-1:0] : trial[MW-1:0];
                r_quo <= {r_quo[QW-2:0], trial_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            fpcc_pkg::ST_CHECK: begin
                if (quo_ok)         r_found <= 1'b1;
                else if (!idx_last) r_idx   <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register: hold a waiting beat, load a new one when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (load_out) begin
            // Drop every field to zero unless a divider was found
            if (r_found && r_in_ok) begin
                r_m_status <= fpcc_pkg::STATUS_OK;
                r_m_data   <= {1'b0, r_code, r_target[TW-1:2], r_idx, r_half,
                               r_quo[fpcc_pkg::FRAC_W-1:0], quo_int};
            end else begin
                r_m_status <= fpcc_pkg::STATUS_BAD;
                r_m_data   <= '0;
            end
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = r_m_data;
    assign o_m_tuser[0] = r_m_status;

endmodule

// File: src/fpcc_chk.sv
// Port-level checker for the fractional PLL coefficient calculator, bound
// to the top level. Depends on fpcc_pkg.
module fpcc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // One beat in flight: no second input straight after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while busy");

    // Failed search clears every field
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] == fpcc_pkg::STATUS_BAD |-> o_m_tdata == 64'd0)
        else $error("invalid result carries data");

    // Found settings always have N inside the PLL's range
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] == fpcc_pkg::STATUS_OK |->
            o_m_tdata[3:0] >= fpcc_pkg::N_MIN && o_m_tdata[3:0] <= fpcc_pkg::N_MAX)
        else $error("PLL integer part out of range");

endmodule

bind fractional_pll_coeff_calc fpcc_chk u_fpcc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
